FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the depth plane band filter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/dpbf_pkg.sv
// ----------------------------------------------------------------------------
// dpbf_pkg
// Fixed widths, register map, reset values and configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package dpbf_pkg;

	localparam int DEPTH_W    = 16;
	localparam int COEFF_W    = 32;
	localparam int LIM_W      = 21;
	// limit plus offset, one bit of growth
	localparam int BND_W      = LIM_W + 1;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr word address
	typedef enum logic [2:0] {
		REG_COEFF_COL    = 3'd0,
		REG_COEFF_ROW    = 3'd1,
		REG_COEFF_BASE   = 3'd2,
		REG_PLANE_OFFSET = 3'd3,
		REG_LOWER_LIMIT  = 3'd4,
		REG_UPPER_LIMIT  = 3'd5
	} reg_idx_t;

	localparam logic signed [COEFF_W-1:0] RST_COEFF_COL    = 32'sd0;
	localparam logic signed [COEFF_W-1:0] RST_COEFF_ROW    = 32'sd0;
	localparam logic signed [COEFF_W-1:0] RST_COEFF_BASE   = 32'sd268435456;
	localparam logic signed [LIM_W-1:0]   RST_PLANE_OFFSET = 21'sd0;
	localparam logic signed [LIM_W-1:0]   RST_LOWER_LIMIT  = -21'sd300;
	localparam logic signed [LIM_W-1:0]   RST_UPPER_LIMIT  = -21'sd10;

	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff_col;
		logic signed [COEFF_W-1:0] coeff_row;
		logic signed [COEFF_W-1:0] coeff_base;
		logic signed [LIM_W-1:0]   plane_offset;
		logic signed [LIM_W-1:0]   lower_limit;
		logic signed [LIM_W-1:0]   upper_limit;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/dpbf_stream_if.sv
// ----------------------------------------------------------------------------
// dpbf_stream_if
// Valid/ready pixel channels: input pixel with coordinates, filtered output.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpbf_pix_in_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic [dpbf_pkg::DEPTH_W-1:0] depth_in;
	logic [COORD_BITS-1:0]        col;
	logic [COORD_BITS-1:0]        row;

	modport source (output valid, output depth_in, output col, output row, input ready);
	modport sink   (input valid, input depth_in, input col, input row, output ready);
endinterface

interface dpbf_pix_out_if;
	logic                         valid;
	logic                         ready;
	logic [dpbf_pkg::DEPTH_W-1:0] depth_out;
	logic                         inside_band;

	modport source (output valid, output depth_out, output inside_band, input ready);
	modport sink   (input valid, input depth_out, input inside_band, output ready);
endinterface

`default_nettype wire

FILE: src/dpbf_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpbf_cfg_regs
// APB register file holding plane coefficients, offset and band limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbf_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dpbf_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [dpbf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [dpbf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output dpbf_pkg::cfg_t                         cfg
);

	localparam int PAD_W = dpbf_pkg::APB_DATA_W - dpbf_pkg::LIM_W;

	dpbf_pkg::cfg_t   cfg_q;
	dpbf_pkg::reg_idx_t idx;
	logic             wr_en;

	// word index; byte lane bits are ignored
	assign idx    = dpbf_pkg::reg_idx_t'(paddr[dpbf_pkg::APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes; unmapped indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff_col    <= dpbf_pkg::RST_COEFF_COL;
			cfg_q.coeff_row    <= dpbf_pkg::RST_COEFF_ROW;
			cfg_q.coeff_base   <= dpbf_pkg::RST_COEFF_BASE;
			cfg_q.plane_offset <= dpbf_pkg::RST_PLANE_OFFSET;
			cfg_q.lower_limit  <= dpbf_pkg::RST_LOWER_LIMIT;
			cfg_q.upper_limit  <= dpbf_pkg::RST_UPPER_LIMIT;
		end else if (wr_en) begin
			case (idx)
				dpbf_pkg::REG_COEFF_COL: begin
					cfg_q.coeff_col <= pwdata;
				end
				dpbf_pkg::REG_COEFF_ROW: begin
					cfg_q.coeff_row <= pwdata;
				end
				dpbf_pkg::REG_COEFF_BASE: begin
					cfg_q.coeff_base <= pwdata;
				end
				dpbf_pkg::REG_PLANE_OFFSET: begin
					cfg_q.plane_offset <= pwdata[dpbf_pkg::LIM_W-1:0];
				end
				dpbf_pkg::REG_LOWER_LIMIT: begin
					cfg_q.lower_limit <= pwdata[dpbf_pkg::LIM_W-1:0];
				end
				dpbf_pkg::REG_UPPER_LIMIT: begin
					cfg_q.upper_limit <= pwdata[dpbf_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux, narrow registers zero padded
	always_comb begin
		case (idx)
			dpbf_pkg::REG_COEFF_COL:    prdata = cfg_q.coeff_col;
			dpbf_pkg::REG_COEFF_ROW:    prdata = cfg_q.coeff_row;
			dpbf_pkg::REG_COEFF_BASE:   prdata = cfg_q.coeff_base;
			dpbf_pkg::REG_PLANE_OFFSET: prdata = {{PAD_W{1'b0}}, cfg_q.plane_offset};
			dpbf_pkg::REG_LOWER_LIMIT:  prdata = {{PAD_W{1'b0}}, cfg_q.lower_limit};
			dpbf_pkg::REG_UPPER_LIMIT:  prdata = {{PAD_W{1'b0}}, cfg_q.upper_limit};
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/dpbf_scale.sv
// ----------------------------------------------------------------------------
// dpbf_scale
// Stages 1-2: per-pixel scale factor s = cu*col + cv*row + cc in fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbf_scale #(
	parameter int COORD_BITS = 12,
	parameter int SUM_W      = 46
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dpbf_pkg::cfg_t                    cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [dpbf_pkg::DEPTH_W-1:0]      in_depth,
	input  wire logic [COORD_BITS-1:0]             in_col,
	input  wire logic [COORD_BITS-1:0]             in_row,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [dpbf_pkg::DEPTH_W-1:0]      out_depth,
	output logic signed [SUM_W-1:0]                out_scale
);

	// signed coefficient times non-negative coordinate
	localparam int PRODC_W = dpbf_pkg::COEFF_W + COORD_BITS + 1;

	logic                           valid_s1, valid_s2;
	logic                           ready_s1, ready_s2;
	logic signed [PRODC_W-1:0]      prod_col_s1, prod_row_s1;
	logic [dpbf_pkg::DEPTH_W-1:0]   depth_s1, depth_s2;
	logic signed [SUM_W-1:0]        scale_s2;

	// per-stage ready lets bubbles collapse under backpressure
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// stage 1: coordinate products
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_col_s1 <= cfg.coeff_col * $signed({1'b0, in_col});
			prod_row_s1 <= cfg.coeff_row * $signed({1'b0, in_row});
			depth_s1    <= in_depth;
		end
	end

	// stage 2: three-term sum
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			scale_s2 <= SUM_W'(prod_col_s1) + SUM_W'(prod_row_s1) + SUM_W'(cfg.coeff_base);
			depth_s2 <= depth_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_depth = depth_s2;
	assign out_scale = scale_s2;

endmodule

`default_nettype wire

FILE: src/dpbf_product.sv
// ----------------------------------------------------------------------------
// dpbf_product
// Stages 3-4: exact depth*scale product from two half-width multiplies,
// plus the offset-shifted band edges.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbf_product #(
	parameter int SUM_W  = 46,
	parameter int PROD_W = 62
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dpbf_pkg::cfg_t                    cfg,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [dpbf_pkg::DEPTH_W-1:0]      in_depth,
	input  wire logic signed [SUM_W-1:0]           in_scale,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [dpbf_pkg::DEPTH_W-1:0]      out_depth,
	output logic signed [PROD_W-1:0]               out_prod,
	output logic signed [dpbf_pkg::BND_W-1:0]      out_lo_bnd,
	output logic signed [dpbf_pkg::BND_W-1:0]      out_hi_bnd
);

	localparam int LO_W  = SUM_W / 2;
	localparam int HI_W  = SUM_W - LO_W;
	localparam int PLO_W = dpbf_pkg::DEPTH_W + LO_W;
	localparam int PHI_W = dpbf_pkg::DEPTH_W + 1 + HI_W;

	localparam int BW = dpbf_pkg::BND_W;

	logic                           valid_s3, valid_s4;
	logic                           ready_s3, ready_s4;
	logic [PLO_W-1:0]               plo_s3;
	logic signed [PHI_W-1:0]        phi_s3;
	logic [dpbf_pkg::DEPTH_W-1:0]   depth_s3, depth_s4;
	logic signed [PROD_W-1:0]       prod_s4;
	logic signed [BW-1:0]           lo_bnd_s4, hi_bnd_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) valid_s3 <= in_valid;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 3: depth times low (unsigned) and high (signed) halves of scale
	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			plo_s3   <= in_depth * in_scale[LO_W-1:0];
			phi_s3   <= $signed({1'b0, in_depth}) * $signed(in_scale[SUM_W-1:LO_W]);
			depth_s3 <= in_depth;
		end
	end

	// stage 4: recombine partial products; band edges moved by the offset
	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			prod_s4   <= (PROD_W'(phi_s3) <<< LO_W) + PROD_W'(plo_s3);
			lo_bnd_s4 <= BW'(cfg.lower_limit) + BW'(cfg.plane_offset);
			hi_bnd_s4 <= BW'(cfg.upper_limit) + BW'(cfg.plane_offset);
			depth_s4  <= depth_s3;
		end
	end

	assign out_valid  = valid_s4;
	assign out_depth  = depth_s4;
	assign out_prod   = prod_s4;
	assign out_lo_bnd = lo_bnd_s4;
	assign out_hi_bnd = hi_bnd_s4;

endmodule

`default_nettype wire

FILE: src/dpbf_band_cmp.sv
// ----------------------------------------------------------------------------
// dpbf_band_cmp
// Stage 5: exact band test on scaled integers; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbf_band_cmp #(
	parameter int PROD_W          = 62,
	parameter int COEFF_FRAC_BITS = 28
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [dpbf_pkg::DEPTH_W-1:0]      in_depth,
	input  wire logic signed [PROD_W-1:0]          in_prod,
	input  wire logic signed [dpbf_pkg::BND_W-1:0] in_lo_bnd,
	input  wire logic signed [dpbf_pkg::BND_W-1:0] in_hi_bnd,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [dpbf_pkg::DEPTH_W-1:0]      out_depth,
	output logic                                   out_inside
);

	localparam int EDGE_W = dpbf_pkg::BND_W + COEFF_FRAC_BITS;
	localparam int CMP_W  = (PROD_W > EDGE_W) ? PROD_W : EDGE_W;

	logic                           valid_s5, ready_s5;
	logic [dpbf_pkg::DEPTH_W-1:0]   depth_s5;
	logic                           inside_s5;
	logic signed [CMP_W-1:0]        prod_x, edge_lo, edge_hi;
	logic                           band_hit;

	// height*2^F + offset*2^F compared against limit edges in the same scale
	assign prod_x   = CMP_W'(in_prod);
	assign edge_lo  = CMP_W'(in_lo_bnd) <<< COEFF_FRAC_BITS;
	assign edge_hi  = CMP_W'(in_hi_bnd) <<< COEFF_FRAC_BITS;
	assign band_hit = (prod_x >= edge_lo) && (prod_x <= edge_hi);

	assign ready_s5 = !valid_s5 || out_ready;
	assign in_ready = ready_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s5) begin
			valid_s5 <= in_valid;
		end
	end

	// zero depth passes as zero regardless of the test
	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			inside_s5 <= band_hit;
			depth_s5  <= band_hit ? in_depth : '0;
		end
	end

	assign out_valid  = valid_s5;
	assign out_depth  = depth_s5;
	assign out_inside = inside_s5;

endmodule

`default_nettype wire

FILE: src/depth_plane_band_filter_top.sv
// ----------------------------------------------------------------------------
// depth_plane_band_filter_top
// Keeps depth pixels whose height above a configured plane lies in a band.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the output is not stalled, and each
// pixel yields exactly one result. From input transaction to output valid
// the stages form the scale factor (coordinate multiplies, then the
// three-term sum), then the exact depth*scale product (split multiply, then
// recombine), then register the band compare. The rate is set by this fully
// pipelined datapath; each stage holds independently under backpressure, so
// empty stages still fill while a result waits. The test is exact on scaled
// integers (lower <= depth*s/2^F - offset <= upper), with no rounding or
// saturation. Registers sit on an APB port at byte address 4*index and must
// be written only while no pixel is in flight. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_plane_band_filter_top #(
	parameter int COORD_BITS      = 12,
	parameter int COEFF_FRAC_BITS = 28
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	dpbf_pix_in_if.sink                            pix_in,
	dpbf_pix_out_if.source                         pix_out,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [dpbf_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [dpbf_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [dpbf_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam int SUM_W  = dpbf_pkg::COEFF_W + COORD_BITS + 2;
	localparam int PROD_W = SUM_W + dpbf_pkg::DEPTH_W;

	dpbf_pkg::cfg_t                 cfg;

	logic                           sc_valid, sc_ready;
	logic [dpbf_pkg::DEPTH_W-1:0]   sc_depth;
	logic signed [SUM_W-1:0]        sc_scale;

	logic                           pr_valid, pr_ready;
	logic [dpbf_pkg::DEPTH_W-1:0]   pr_depth;
	logic signed [PROD_W-1:0]       pr_prod;
	logic signed [dpbf_pkg::BND_W-1:0] pr_lo_bnd, pr_hi_bnd;

	// configuration registers
	dpbf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// scale factor stages
	dpbf_scale #(
		.COORD_BITS (COORD_BITS),
		.SUM_W      (SUM_W)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_depth  (pix_in.depth_in),
		.in_col    (pix_in.col),
		.in_row    (pix_in.row),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.out_depth (sc_depth),
		.out_scale (sc_scale)
	);

	// depth product stages
	dpbf_product #(
		.SUM_W  (SUM_W),
		.PROD_W (PROD_W)
	) u_prod (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (sc_valid),
		.in_ready   (sc_ready),
		.in_depth   (sc_depth),
		.in_scale   (sc_scale),
		.out_valid  (pr_valid),
		.out_ready  (pr_ready),
		.out_depth  (pr_depth),
		.out_prod   (pr_prod),
		.out_lo_bnd (pr_lo_bnd),
		.out_hi_bnd (pr_hi_bnd)
	);

	// band compare and output register
	dpbf_band_cmp #(
		.PROD_W          (PROD_W),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pr_valid),
		.in_ready   (pr_ready),
		.in_depth   (pr_depth),
		.in_prod    (pr_prod),
		.in_lo_bnd  (pr_lo_bnd),
		.in_hi_bnd  (pr_hi_bnd),
		.out_valid  (pix_out.valid),
		.out_ready  (pix_out.ready),
		.out_depth  (pix_out.depth_out),
		.out_inside (pix_out.inside_band)
	);

endmodule

`default_nettype wire

FILE: src/dpbf_checker.sv
// ----------------------------------------------------------------------------
// dpbf_checker
// Port-level checks on the band filter's streaming behavior; bound to top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dpbf_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [dpbf_pkg::DEPTH_W-1:0] depth_out,
	input wire logic                         inside_band
);

	// a rejected pixel is always output as zero
	`ASSERT_IMPL(a_zero_outside, clk, arst_n, out_valid && !inside_band, depth_out == '0)

	// with the sink ready, every stage drains, so the input is ready
	`ASSERT_IMPL(a_ready_passes, clk, arst_n, out_ready, in_ready)

	// an accepted pixel reaches out_valid when the output is never stalled
	`ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 out_ready [*4], out_valid)

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(depth_out) && $stable(inside_band))

endmodule

bind depth_plane_band_filter_top dpbf_checker u_dpbf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix_in.valid),
	.in_ready    (pix_in.ready),
	.out_valid   (pix_out.valid),
	.out_ready   (pix_out.ready),
	.depth_out   (pix_out.depth_out),
	.inside_band (pix_out.inside_band)
);

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth plane band filter. Pixels go in through
// a valid/ready driver fed from a queue. Each accepted transaction is scored
// against an exact band test on wide integers. A monitor compares every
// output transaction with the oldest expected result. Registers are written
// over APB only while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 28;
	localparam int PROD_W       = 80;
	localparam int PIPE_LATENCY = 5;
	localparam int LONG_STALL   = 200;
	localparam int RAND_PHASES  = 9;
	localparam int PHASE_ITEMS  = 50;
	localparam int TIMEOUT      = 400000;
	localparam int ONE_Q        = 268435456;
	localparam int LIM_MAX      = 1048575;
	localparam int LIM_MIN      = -1048576;
	localparam int DW           = dpbf_pkg::DEPTH_W;
	localparam int LW           = dpbf_pkg::LIM_W;
	localparam int JUNK_W       = dpbf_pkg::APB_DATA_W - dpbf_pkg::LIM_W;
	// register slots past the map; writes there must be dropped
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [DW-1:0]         depth;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
	} pixel_t;

	typedef struct {
		logic [DW-1:0] depth;
		logic          hit;
	} band_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                            psel    = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite  = 1'b0;
	logic [dpbf_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [dpbf_pkg::APB_DATA_W-1:0] pwdata  = '0;
	logic [dpbf_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	dpbf_pix_in_if #(.COORD_BITS(COORD_BITS)) pix_in ();
	dpbf_pix_out_if pix_out ();

	pixel_t          pixel_queue[$];
	band_result_t    band_expect_q[$];
	dpbf_pkg::cfg_t  band_cfg;
	int              mismatch_cnt = 0;
	int              src_idle_pct = 0;
	int              snk_idle_pct = 0;
	logic            sink_hold    = 1'b0;
	logic            stall_go     = 1'b0;

	depth_plane_band_filter_top #(
		.COORD_BITS      (COORD_BITS),
		.COEFF_FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	always #1 clk = ~clk;

	// known pixel bus values from time zero
	initial begin
		pix_in.valid    = 1'b0;
		pix_in.depth_in = '0;
		pix_in.col      = '0;
		pix_in.row      = '0;
		pix_out.ready   = 1'b0;
	end

	// depth * (cu*col + cv*row + cc), exact, still scaled by 2^FRAC_BITS
	function automatic logic signed [PROD_W-1:0] depth_times_scale(
			input dpbf_pkg::cfg_t c, input pixel_t px);
		logic signed [PROD_W-1:0] cu, cv, cc, cx, cy, dd, s;
		cu = $signed(c.coeff_col);
		cv = $signed(c.coeff_row);
		cc = $signed(c.coeff_base);
		cx = {1'b0, px.col};
		cy = {1'b0, px.row};
		dd = {1'b0, px.depth};
		s  = cu * cx + cv * cy + cc;
		return dd * s;
	endfunction

	// band test on scaled integers: (lo+off)*2^F <= depth*s <= (hi+off)*2^F
	function automatic band_result_t predict_band(input pixel_t px);
		logic signed [PROD_W-1:0] p, lo, hi, off, t_lo, t_hi;
		band_result_t r;
		p    = depth_times_scale(band_cfg, px);
		lo   = $signed(band_cfg.lower_limit);
		hi   = $signed(band_cfg.upper_limit);
		off  = $signed(band_cfg.plane_offset);
		t_lo = (lo + off) <<< FRAC_BITS;
		t_hi = (hi + off) <<< FRAC_BITS;
		r.hit   = (p >= t_lo) && (p <= t_hi);
		r.depth = r.hit ? px.depth : '0;
		return r;
	endfunction

	function automatic dpbf_pkg::cfg_t make_cfg(input int cu, input int cv, input int cc,
			input int off, input int lo, input int hi);
		dpbf_pkg::cfg_t c;
		c.coeff_col    = cu;
		c.coeff_row    = cv;
		c.coeff_base   = cc;
		c.plane_offset = off[LW-1:0];
		c.lower_limit  = lo[LW-1:0];
		c.upper_limit  = hi[LW-1:0];
		return c;
	endfunction

	function automatic int rand_signed(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic int clamp_limit(input longint v);
		if (v > LIM_MAX)
			return LIM_MAX;
		if (v < LIM_MIN)
			return LIM_MIN;
		return int'(v);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_cnt++;
	endtask

	// APB write: setup, access; register lands at the end of access
	task automatic apb_write(input logic [2:0] idx,
			input logic [dpbf_pkg::APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			dpbf_pkg::REG_COEFF_COL:    band_cfg.coeff_col    = data;
			dpbf_pkg::REG_COEFF_ROW:    band_cfg.coeff_row    = data;
			dpbf_pkg::REG_COEFF_BASE:   band_cfg.coeff_base   = data;
			dpbf_pkg::REG_PLANE_OFFSET: band_cfg.plane_offset = data[LW-1:0];
			dpbf_pkg::REG_LOWER_LIMIT:  band_cfg.lower_limit  = data[LW-1:0];
			dpbf_pkg::REG_UPPER_LIMIT:  band_cfg.upper_limit  = data[LW-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// all six registers; junk in the unused upper bits of the narrow ones
	task automatic write_band_cfg(input dpbf_pkg::cfg_t c);
		logic [JUNK_W-1:0] junk;
		junk = JUNK_W'($urandom);
		apb_write(dpbf_pkg::REG_COEFF_COL, c.coeff_col);
		apb_write(dpbf_pkg::REG_COEFF_ROW, c.coeff_row);
		apb_write(dpbf_pkg::REG_COEFF_BASE, c.coeff_base);
		apb_write(dpbf_pkg::REG_PLANE_OFFSET, {junk, c.plane_offset});
		junk = JUNK_W'($urandom);
		apb_write(dpbf_pkg::REG_LOWER_LIMIT, {junk, c.lower_limit});
		junk = JUNK_W'($urandom);
		apb_write(dpbf_pkg::REG_UPPER_LIMIT, {junk, c.upper_limit});
		@(negedge clk);
	endtask

	task automatic queue_pixel(input int d, input int c, input int r);
		pixel_t px;
		px.depth = d[DW-1:0];
		px.col   = c[COORD_BITS-1:0];
		px.row   = r[COORD_BITS-1:0];
		pixel_queue = {pixel_queue, px};
	endtask

	// wait until every queued pixel is in and every result is out
	task automatic drain_results();
		while (pixel_queue.size() != 0 || pix_in.valid || band_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// plane roughly facing the camera, band placed around one anchor pixel
	task automatic pick_scene(output dpbf_pkg::cfg_t c, output pixel_t anchor);
		logic signed [PROD_W-1:0] p;
		longint h;
		c.coeff_col    = rand_signed(32768);
		c.coeff_row    = rand_signed(32768);
		c.coeff_base   = ONE_Q + rand_signed(67108864);
		c.plane_offset = LW'(rand_signed(20000));
		anchor.depth   = DW'($urandom_range(8000, 500));
		anchor.col     = COORD_BITS'($urandom);
		anchor.row     = COORD_BITS'($urandom);
		p = depth_times_scale(c, anchor);
		h = longint'(p >>> FRAC_BITS) - longint'($signed(c.plane_offset));
		c.lower_limit  = LW'(clamp_limit(h - longint'($urandom_range(3000))));
		c.upper_limit  = LW'(clamp_limit(h + longint'($urandom_range(3000))));
	endtask

	// mostly pixels near the anchor, with no-data, saturated and wild ones
	function automatic pixel_t random_pixel(input pixel_t anchor);
		pixel_t px;
		int     sel, d;
		sel = $urandom_range(99);
		if (sel < 8) begin
			px.depth = '0;
		end else if (sel < 12) begin
			px.depth = '1;
		end else if (sel < 35) begin
			px.depth = DW'($urandom);
		end else begin
			d = int'(anchor.depth) + rand_signed(300);
			px.depth = (d < 1) ? 16'd1 : d[DW-1:0];
		end
		if ($urandom_range(1)) begin
			px.col = COORD_BITS'($urandom);
			px.row = COORD_BITS'($urandom);
		end else begin
			px.col = anchor.col ^ COORD_BITS'($urandom_range(63));
			px.row = anchor.row ^ COORD_BITS'($urandom_range(63));
		end
		return px;
	endfunction

	// driver: scores each input transaction, then offers the queue head
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_in.valid && pix_in.ready) begin
				band_expect_q = {band_expect_q, predict_band('{pix_in.depth_in,
					pix_in.col, pix_in.row})};
				pixel_queue.delete(0);
			end
			if (!(pix_in.valid && !pix_in.ready)) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					pix_in.valid    <= 1'b1;
					pix_in.depth_in <= pixel_queue[0].depth;
					pix_in.col      <= pixel_queue[0].col;
					pix_in.row      <= pixel_queue[0].row;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure plus the long hold-off
	always @(posedge clk)
		pix_out.ready <= arst_n && !sink_hold && ($urandom_range(99) >= snk_idle_pct);

	// monitor: compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		band_result_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (band_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result depth_out=%0d inside_band=%0b",
					pix_out.depth_out, pix_out.inside_band));
			end else begin
				want = band_expect_q[0];
				band_expect_q.delete(0);
				if (pix_out.depth_out !== want.depth)
					report_mismatch($sformatf("depth_out %0d, expected %0d",
						pix_out.depth_out, want.depth));
				if (pix_out.inside_band !== want.hit)
					report_mismatch($sformatf("inside_band %0b, expected %0b",
						pix_out.inside_band, want.hit));
			end
		end
	end

	// long receiver hold-off, counted here
	initial begin
		wait (stall_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (LONG_STALL) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// run limit
	initial begin
		#(TIMEOUT);
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin
		dpbf_pkg::cfg_t scene;
		pixel_t         anchor;
		band_cfg.coeff_col    = dpbf_pkg::RST_COEFF_COL;
		band_cfg.coeff_row    = dpbf_pkg::RST_COEFF_ROW;
		band_cfg.coeff_base   = dpbf_pkg::RST_COEFF_BASE;
		band_cfg.plane_offset = dpbf_pkg::RST_PLANE_OFFSET;
		band_cfg.lower_limit  = dpbf_pkg::RST_LOWER_LIMIT;
		band_cfg.upper_limit  = dpbf_pkg::RST_UPPER_LIMIT;
		src_idle_pct = 16;
		snk_idle_pct = 64;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: heights are non-negative, band lies below zero
		queue_pixel(0, 0, 0);
		queue_pixel(65535, 4095, 4095);
		queue_pixel(100, 4095, 0);
		drain_results();

		// flat plane 1000 mm away, band 0..500 above it; edges hit exactly
		write_band_cfg(make_cfg(0, 0, ONE_Q, 1000, 0, 500));
		apb_write(REG_SPARE_6, $urandom);
		apb_write(REG_SPARE_7, $urandom);
		@(negedge clk);
		queue_pixel(999, 0, 4095);
		queue_pixel(1000, 17, 33);
		queue_pixel(1500, 4095, 4095);
		queue_pixel(1501, 2048, 1024);
		queue_pixel(0, 5, 5);
		queue_pixel(65535, 0, 0);
		drain_results();

		// no data inside the band: flag set, pixel still zero
		write_band_cfg(make_cfg(0, 0, ONE_Q, 0, -5, 5));
		queue_pixel(0, 1234, 321);
		queue_pixel(5, 0, 0);
		queue_pixel(6, 0, 0);
		drain_results();

		// crossed limits pass nothing
		write_band_cfg(make_cfg(0, 0, ONE_Q, 0, 100, 99));
		queue_pixel(99, 0, 0);
		queue_pixel(100, 0, 0);
		drain_results();
		write_band_cfg(make_cfg(0, 0, ONE_Q, 0, 0, -1));
		queue_pixel(0, 0, 0);
		drain_results();

		// register extremes, positive coefficients
		write_band_cfg(make_cfg(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, LIM_MIN,
			LIM_MIN, LIM_MAX));
		queue_pixel(0, 0, 0);
		queue_pixel(1, 0, 0);
		queue_pixel(65535, 4095, 4095);
		drain_results();

		// register extremes, negative coefficients
		write_band_cfg(make_cfg(32'h80000000, 32'h80000000, 32'h80000000, LIM_MAX,
			LIM_MIN, LIM_MAX));
		queue_pixel(0, 4095, 4095);
		queue_pixel(1, 0, 0);
		drain_results();

		// scale just above one: a fraction past the upper edge is outside
		write_band_cfg(make_cfg(0, 0, ONE_Q + 1, 0, 0, 1000));
		queue_pixel(1000, 0, 0);
		queue_pixel(999, 0, 0);
		drain_results();
		// tilted plane, corner pixel lands exactly on the upper edge
		write_band_cfg(make_cfg(65536, -65536, ONE_Q, 0, 8000, 8191));
		queue_pixel(4096, 4095, 0);
		drain_results();

		// random scenes
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph / 3)
				0: begin src_idle_pct = 16; snk_idle_pct = 64; end
				1: begin src_idle_pct = 64; snk_idle_pct = 16; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			pick_scene(scene, anchor);
			if (ph % 3 == 2) begin
				// raw register noise, every bit free
				scene.coeff_col    = $urandom;
				scene.coeff_row    = $urandom;
				scene.coeff_base   = $urandom;
				scene.plane_offset = LW'($urandom);
				scene.lower_limit  = LW'($urandom);
				scene.upper_limit  = LW'($urandom);
			end
			write_band_cfg(scene);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pixel_queue = {pixel_queue, random_pixel(anchor)};
				// sender pauses midway until the pipe is empty
				if (ph == 4 && i == PHASE_ITEMS / 2)
					drain_results();
			end
			// receiver stops while the sender keeps offering
			if (ph == 6)
				stall_go = 1'b1;
			drain_results();
		end

		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
